// ----- sv/npt_pkg.sv -----
// Shared types and constants for the nearest point table.
// No dependencies; npt_front, npt_back and the top level import this package.
package npt_pkg;

	localparam int MAX_POINTS = 128;
	localparam int COORD_BITS = 16;
	localparam int IDX_BITS = $clog2(MAX_POINTS);
	localparam int CNT_BITS = $clog2(MAX_POINTS + 1);
	localparam int DIST_BITS = 2 * COORD_BITS + 1;
	localparam int SQ_BITS = 2 * COORD_BITS;
	localparam int PT_BITS = 2 * COORD_BITS;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_REMOVE = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADIDX = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_SHIFT,
		BK_FINISH
	} back_state_t;

	typedef struct packed {
		op_t                   op;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
		logic [IDX_BITS-1:0]   entry_index;
	} cmd_t;

	typedef struct packed {
		status_t              status;
		logic [IDX_BITS-1:0]  nearest_index;
		logic [DIST_BITS-1:0] nearest_distance;
		logic [CNT_BITS-1:0]  point_count;
	} rsp_t;

	// queue to back end handshake
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

endpackage

// ----- sv/npt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module npt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/npt_front.sv -----
// Front end: takes command items and holds them in a short queue
// for the back end. Depends on npt_pkg.
module npt_front
	import npt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cmd_valid,
	output logic   cmd_ready,
	input  cmd_t   cmd,
	output qhead_t head,
	input  logic   pop
);

	cmd_t                 entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] fill_q;
	logic                 push;
	logic                 do_pop;

	assign cmd_ready = (fill_q != QCNT_BITS'(QUEUE_DEPTH));
	assign push      = cmd_valid && cmd_ready;
	assign do_pop    = pop && (fill_q != '0);

	assign head.valid = (fill_q != '0);
	assign head.cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && do_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/npt_back.sv -----
// Back end: runs table commands against the point RAM and registers the result.
// Depends on npt_pkg and npt_ram.
module npt_back
	import npt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  qhead_t head,
	output logic   pop,
	output logic   rsp_valid,
	input  logic   rsp_ready,
	output rsp_t   rsp
);

	back_state_t state_q, state_d;

	cmd_t                  cur_q;
	logic [CNT_BITS-1:0]   count_q, count_d;
	logic [CNT_BITS-1:0]   ptr_q;
	logic                  issue;
	logic                  slot_free;

	logic                  ram_we;
	logic [IDX_BITS-1:0]   ram_waddr;
	logic [PT_BITS-1:0]    ram_wdata;
	logic [IDX_BITS-1:0]   ram_raddr;
	logic [PT_BITS-1:0]    ram_rdata;
	logic [COORD_BITS-1:0] rd_x, rd_y;

	// scan pipeline
	logic                  valid_s1, valid_s2, valid_s3;
	logic [IDX_BITS-1:0]   idx_s1, idx_s2, idx_s3;
	logic [COORD_BITS-1:0] dx_s2, dy_s2;
	logic [SQ_BITS-1:0]    sqx_s3, sqy_s3;
	logic [DIST_BITS-1:0]  dist_s3;
	logic [DIST_BITS-1:0]  best_dist_q;
	logic [IDX_BITS-1:0]   best_idx_q;
	logic                  have_q;

	// shift pipeline
	logic                  wr_pend_s1;
	logic [IDX_BITS-1:0]   wr_addr_s1;

	logic                  rsp_load;
	rsp_t                  rsp_d;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	logic                  is_full;
	logic                  bad_idx;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign is_full   = (count_q == CNT_BITS'(MAX_POINTS));
	assign bad_idx   = (CNT_BITS'(head.cmd.entry_index) >= count_q);
	assign rd_x      = ram_rdata[PT_BITS-1:COORD_BITS];
	assign rd_y      = ram_rdata[COORD_BITS-1:0];
	assign dist_s3   = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	npt_ram #(
		.WIDTH(PT_BITS),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (head.valid && slot_free) begin
					if (head.cmd.op == OP_REMOVE && !bad_idx) begin
						state_d = BK_SHIFT;
					end else if (head.cmd.op == OP_QUERY && count_q != '0) begin
						state_d = BK_SCAN;
					end
				end
			end
			BK_SCAN: begin
				if (!issue && !valid_s1 && !valid_s2 && !valid_s3) begin
					state_d = BK_FINISH;
				end
			end
			BK_SHIFT: begin
				if (!issue && !wr_pend_s1) begin
					state_d = BK_FINISH;
				end
			end
			BK_FINISH: begin
				if (slot_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		issue     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = ptr_q[IDX_BITS-1:0];
		rsp_load  = 1'b0;
		rsp_d     = '0;
		count_d   = count_q;
		case (state_q)
			BK_IDLE: begin
				if (head.valid && slot_free) begin
					pop = 1'b1;
					case (head.cmd.op)
						OP_CLEAR: begin
							count_d  = '0;
							rsp_load = 1'b1;
						end
						OP_APPEND: begin
							rsp_load = 1'b1;
							if (is_full) begin
								rsp_d.status = ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = count_q[IDX_BITS-1:0];
								ram_wdata = {head.cmd.pos_x, head.cmd.pos_y};
								count_d   = count_q + 1'b1;
							end
						end
						OP_REMOVE: begin
							if (bad_idx) begin
								rsp_load     = 1'b1;
								rsp_d.status = ST_BADIDX;
							end
						end
						OP_QUERY: begin
							if (count_q == '0) begin
								rsp_load     = 1'b1;
								rsp_d.status = ST_EMPTY;
							end
						end
						default: ;
					endcase
					rsp_d.point_count = count_d;
				end
			end
			BK_SCAN: begin
				issue = (ptr_q < count_q);
			end
			BK_SHIFT: begin
				// read entry i+1 now, write it to entry i next cycle
				issue     = (ptr_q < count_q);
				ram_we    = wr_pend_s1;
				ram_waddr = wr_addr_s1;
				ram_wdata = ram_rdata;
			end
			BK_FINISH: begin
				if (slot_free) begin
					rsp_load = 1'b1;
					if (cur_q.op == OP_REMOVE) begin
						count_d = count_q - 1'b1;
					end else begin
						rsp_d.nearest_index    = best_idx_q;
						rsp_d.nearest_distance = best_dist_q;
					end
					rsp_d.point_count = count_d;
				end
			end
			default: ;
		endcase
	end

	// payload pipeline, no reset needed
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.cmd;
		end
		idx_s1     <= ptr_q[IDX_BITS-1:0];
		wr_addr_s1 <= ptr_q[IDX_BITS-1:0] - 1'b1;
		idx_s2     <= idx_s1;
		dx_s2      <= (rd_x >= cur_q.pos_x) ? rd_x - cur_q.pos_x : cur_q.pos_x - rd_x;
		dy_s2      <= (rd_y >= cur_q.pos_y) ? rd_y - cur_q.pos_y : cur_q.pos_y - rd_y;
		idx_s3     <= idx_s2;
		sqx_s3     <= dx_s2 * dx_s2;
		sqy_s3     <= dy_s2 * dy_s2;
		if (valid_s3 && (!have_q || dist_s3 < best_dist_q)) begin
			best_dist_q <= dist_s3;
			best_idx_q  <= idx_s3;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			wr_pend_s1  <= 1'b0;
			have_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			valid_s1   <= (state_q == BK_SCAN) && issue;
			valid_s2   <= valid_s1;
			valid_s3   <= valid_s2;
			wr_pend_s1 <= (state_q == BK_SHIFT) && issue;
			if (pop) begin
				ptr_q  <= (head.cmd.op == OP_REMOVE) ?
					CNT_BITS'(head.cmd.entry_index) + 1'b1 : '0;
				have_q <= 1'b0;
			end else begin
				if (issue) begin
					ptr_q <= ptr_q + 1'b1;
				end
				if (valid_s3) begin
					have_q <= 1'b1;
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- sv/nearest_point_table_top.sv -----
// Top level of the nearest point table: front queue plus back end.
// Depends on npt_pkg, npt_front, npt_back (and npt_ram below it).
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) carries one operation per item:
//   clear, append a point, remove at an index, or query the nearest point.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one item per
//   command, in command order: status, nearest index and squared distance
//   (query only), and the point count after the operation.
//   A two-entry command queue takes items while the back end is busy or a
//   result waits in the output register.
//   How the back end runs each command:
//     clear, append, and any error case: result registered as the command is taken.
//     query: one distance per cycle over the N stored points; the
//       pipeline is RAM read, abs difference, square, add and compare.
//     remove at index k: entries above k move down one place, one entry
//       moved per cycle through the single read and single write port
//       of the point RAM; none move when k is the last entry.
//   Reset clears the point count and queue; point RAM contents are left as
//   they are since only entries below the count are read.
//   When rsp_ready is low the back end holds its finished result and stops;
//   the queue fills and then cmd_ready falls.
module nearest_point_table_top
	import npt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	qhead_t head;
	logic   pop;

	npt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.head     (head),
		.pop      (pop)
	);

	npt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// error results carry no nearest point
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |->
			rsp.nearest_index == '0 && rsp.nearest_distance == '0)
		else $error("error result with nonzero nearest fields");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> rsp.point_count == '0)
		else $error("empty status with nonzero count");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |->
			rsp.point_count == CNT_BITS'(MAX_POINTS))
		else $error("full status without a full table");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.nearest_index != '0 |->
			CNT_BITS'(rsp.nearest_index) < rsp.point_count)
		else $error("nearest index beyond point count");

	// the back end only pops while the queue holds an item
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");

endmodule
